// ===== src/assert_macros.svh =====
// Concurrent assertion wrappers, clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define LSAM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("lsam assertion failed");

// Check at every edge, reset included.
`define LSAM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("lsam assertion failed");

`endif

// ===== src/lsam_pkg.sv =====
`default_nettype none
package lsam_pkg;

    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned ADC_W      = 12;
    localparam int unsigned SQ_W       = 32;
    localparam int unsigned SUM_W      = 40;
    localparam int unsigned QUO_W      = 32;
    localparam int unsigned LIMIT_W    = 32;
    localparam int unsigned REQ_W      = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned NFLAG      = 5;
    localparam int unsigned DIFF_W     = ADC_W + 2;

    localparam int unsigned FLAG_TEMP    = 0;
    localparam int unsigned FLAG_CURRENT = 1;
    localparam int unsigned FLAG_POWER   = 2;
    localparam int unsigned FLAG_VIB     = 3;
    localparam int unsigned FLAG_SUPPLY  = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE    = 3'd0,
        REQ_REPORT    = 3'd1,
        REQ_LED_OFF   = 3'd2,
        REQ_RELAY_ON  = 3'd3,
        REQ_RELAY_OFF = 3'd4,
        REQ_ALARM_CLR = 3'd5
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUR_OFFSET = 3'd0,
        CFG_CUR_LIMIT  = 3'd1,
        CFG_PWR_LIMIT  = 3'd2,
        CFG_TEMP_LIMIT = 3'd3,
        CFG_SUP_LOW    = 3'd4,
        CFG_SUP_HIGH   = 3'd5,
        CFG_VIB_LIMIT  = 3'd6
    } t_cfg;

    localparam logic [ADC_W-1:0]        CUR_OFFSET_RST = 12'd3102;
    localparam logic [ADC_W-1:0]        CUR_LIMIT_RST  = 12'd124;
    localparam logic [ADC_W-1:0]        PWR_LIMIT_RST  = 12'd620;
    localparam logic signed [ADC_W-1:0] TEMP_LIMIT_RST = 12'sd496;
    localparam logic [ADC_W-1:0]        SUP_LOW_RST    = 12'd564;
    localparam logic [ADC_W-1:0]        SUP_HIGH_RST   = 12'd2933;
    localparam logic [LIMIT_W-1:0]      VIB_LIMIT_RST  = 32'd37748736;

    localparam logic signed [DIFF_W-1:0] CUR_DEADBAND  = 14'sd6;
    localparam logic signed [ADC_W-1:0]  TEMP_INV_HIGH = 12'sd1360;
    localparam logic signed [ADC_W-1:0]  TEMP_INV_LOW  = -12'sd2032;

endpackage
`default_nettype wire

// ===== src/lsam_if.sv =====
`default_nettype none
interface lsam_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [lsam_pkg::REQ_W-1:0]               req_type;
    logic signed [lsam_pkg::AXIS_W-1:0]       accel_x;
    logic signed [lsam_pkg::AXIS_W-1:0]       accel_y;
    logic signed [lsam_pkg::AXIS_W-1:0]       accel_z;
    logic [lsam_pkg::ADC_W-1:0]               current_adc;
    logic [lsam_pkg::ADC_W-1:0]               supply_adc;
    logic signed [lsam_pkg::ADC_W-1:0]        temperature;

    modport source (output valid, req_type, accel_x, accel_y, accel_z,
                    current_adc, supply_adc, temperature, input ready);
    modport sink   (input valid, req_type, accel_x, accel_y, accel_z,
                    current_adc, supply_adc, temperature, output ready);
endinterface

interface lsam_res_if;
    logic                          valid;
    logic                          ready;
    logic                          alarm_temp;
    logic                          alarm_current;
    logic                          alarm_power;
    logic                          alarm_vibration;
    logic                          alarm_supply;
    logic                          alarm_any;
    logic                          relay_closed;
    logic                          buzzer_on;
    logic                          led_on;
    logic                          latched;
    logic [lsam_pkg::QUO_W-1:0]    mean_square;

    modport source (output valid, alarm_temp, alarm_current, alarm_power,
                    alarm_vibration, alarm_supply, alarm_any, relay_closed,
                    buzzer_on, led_on, latched, mean_square, input ready);
    modport sink   (input valid, alarm_temp, alarm_current, alarm_power,
                    alarm_vibration, alarm_supply, alarm_any, relay_closed,
                    buzzer_on, led_on, latched, mean_square, output ready);
endinterface

interface lsam_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lsam_pkg::CFG_IDX_W-1:0]    index;
    logic [lsam_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/lsam_ram.sv =====
`default_nettype none
module lsam_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/latched_sensor_alarm_monitor_unit.sv =====
// Channel   Dir  Port    Transfer when
// request   in   i_req   i_req.valid && i_req.ready
// result    out  o_res   o_res.valid && o_res.ready
// config    in   i_cfg   i_cfg.valid (ready held high)
//
// One request per cycle when not stalled; each passes the input register, then one
// pass of squaring, ring update and flag compares into the state registers, which
// double as the result register. WINDOW_DEPTH must be a power of two (the block
// does not check it), so the mean square is a shift of the window sum. Synchronous
// active-low reset; the magnitude ring needs no clearing pass, a wrap flag masks
// entries not yet written. A stalled result holds the state; the input register
// fills behind it and the request side stalls when both are full.
`default_nettype none
module latched_sensor_alarm_monitor_unit #(
    parameter int unsigned WINDOW_DEPTH = 256,
    parameter int unsigned ACCEL_WIDTH  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsam_req_if.sink   i_req,
    lsam_res_if.source o_res,
    lsam_cfg_if.sink   i_cfg
);

    localparam int unsigned IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int unsigned NSTAGE = 2;
    localparam int unsigned MUL_W  = 2 * ACCEL_WIDTH;
    localparam int unsigned SQ_W   = lsam_pkg::SQ_W;
    localparam int unsigned SUM_W  = lsam_pkg::SUM_W;
    localparam int unsigned QUO_W  = lsam_pkg::QUO_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

    // handshake chain
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE:0]   adv;
    logic              commit;

    always_comb begin
        adv[NSTAGE] = o_res.ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_req.ready = adv[0];
    assign commit      = r_vld[0] && adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // configuration
    logic [lsam_pkg::ADC_W-1:0]        r_cur_offset;
    logic [lsam_pkg::ADC_W-1:0]        r_cur_limit;
    logic [lsam_pkg::ADC_W-1:0]        r_pwr_limit;
    logic signed [lsam_pkg::ADC_W-1:0] r_temp_limit;
    logic [lsam_pkg::ADC_W-1:0]        r_sup_low;
    logic [lsam_pkg::ADC_W-1:0]        r_sup_high;
    logic [lsam_pkg::LIMIT_W-1:0]      r_vib_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_offset <= lsam_pkg::CUR_OFFSET_RST;
            r_cur_limit  <= lsam_pkg::CUR_LIMIT_RST;
            r_pwr_limit  <= lsam_pkg::PWR_LIMIT_RST;
            r_temp_limit <= lsam_pkg::TEMP_LIMIT_RST;
            r_sup_low    <= lsam_pkg::SUP_LOW_RST;
            r_sup_high   <= lsam_pkg::SUP_HIGH_RST;
            r_vib_limit  <= lsam_pkg::VIB_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (lsam_pkg::t_cfg'(i_cfg.index))
                lsam_pkg::CFG_CUR_OFFSET: begin
                    r_cur_offset <= i_cfg.data[lsam_pkg::ADC_W-1:0];
                end
                lsam_pkg::CFG_CUR_LIMIT: begin
                    r_cur_limit <= i_cfg.data[lsam_pkg::ADC_W-1:0];
                end
                lsam_pkg::CFG_PWR_LIMIT: begin
                    r_pwr_limit <= i_cfg.data[lsam_pkg::ADC_W-1:0];
                end
                lsam_pkg::CFG_TEMP_LIMIT: begin
                    r_temp_limit <= signed'(i_cfg.data[lsam_pkg::ADC_W-1:0]);
                end
                lsam_pkg::CFG_SUP_LOW: begin
                    r_sup_low <= i_cfg.data[lsam_pkg::ADC_W-1:0];
                end
                lsam_pkg::CFG_SUP_HIGH: begin
                    r_sup_high <= i_cfg.data[lsam_pkg::ADC_W-1:0];
                end
                lsam_pkg::CFG_VIB_LIMIT: begin
                    r_vib_limit <= i_cfg.data[lsam_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    logic [lsam_pkg::REQ_W-1:0]        r0_type;
    logic signed [ACCEL_WIDTH-1:0]     r0_x;
    logic signed [ACCEL_WIDTH-1:0]     r0_y;
    logic signed [ACCEL_WIDTH-1:0]     r0_z;
    logic [lsam_pkg::ADC_W-1:0]        r0_cur;
    logic [lsam_pkg::ADC_W-1:0]        r0_sup;
    logic signed [lsam_pkg::ADC_W-1:0] r0_temp;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_type <= i_req.req_type;
            r0_x    <= signed'(i_req.accel_x[ACCEL_WIDTH-1:0]);
            r0_y    <= signed'(i_req.accel_y[ACCEL_WIDTH-1:0]);
            r0_z    <= signed'(i_req.accel_z[ACCEL_WIDTH-1:0]);
            r0_cur  <= i_req.current_adc;
            r0_sup  <= i_req.supply_adc;
            r0_temp <= i_req.temperature;
        end
    end

    // squared magnitude
    logic signed [MUL_W-1:0] sq_x;
    logic signed [MUL_W-1:0] sq_y;
    logic signed [MUL_W-1:0] sq_z;
    logic [SQ_W-1:0]         n_sq;

    assign sq_x = r0_x * r0_x;
    assign sq_y = r0_y * r0_y;
    assign sq_z = r0_z * r0_z;
    assign n_sq = SQ_W'(unsigned'(sq_x)) + SQ_W'(unsigned'(sq_y)) + SQ_W'(unsigned'(sq_z));

    // block state, also the result register
    logic [lsam_pkg::NFLAG-1:0] r_flags, n_flags;
    logic                       r_latch, n_latch;
    logic                       r_relay, n_relay;
    logic                       r_buzzer, n_buzzer;
    logic                       r_user_off, n_user_off;
    logic                       r_led, n_led;
    logic [SUM_W-1:0]           r_sum, n_sum;
    logic [IDX_W-1:0]           r_widx, n_widx;
    logic                       r_full, n_full;

    logic [SQ_W-1:0]                    ram_rdata;
    logic [SQ_W-1:0]                    old_sq;
    logic                               ram_we;
    logic [QUO_W-1:0]                   mean_sq;
    logic signed [lsam_pkg::DIFF_W-1:0] diff_raw;
    logic signed [lsam_pkg::DIFF_W-1:0] diff;
    logic [lsam_pkg::NFLAG-1:0]         new_flags;

    assign old_sq   = r_full ? ram_rdata : '0;
    assign mean_sq  = QUO_W'(r_sum >> IDX_W);
    assign diff_raw = signed'({2'b00, r0_cur}) - signed'({2'b00, r_cur_offset});
    assign diff     = (diff_raw >= -lsam_pkg::CUR_DEADBAND
                       && diff_raw <= lsam_pkg::CUR_DEADBAND) ? '0 : diff_raw;

    always_comb begin
        new_flags = '0;
        new_flags[lsam_pkg::FLAG_TEMP] = (r0_temp != lsam_pkg::TEMP_INV_HIGH)
                                      && (r0_temp != lsam_pkg::TEMP_INV_LOW)
                                      && (r0_temp > r_temp_limit);
        new_flags[lsam_pkg::FLAG_CURRENT] = diff > signed'({2'b00, r_cur_limit});
        new_flags[lsam_pkg::FLAG_POWER]   = diff > signed'({2'b00, r_pwr_limit});
        new_flags[lsam_pkg::FLAG_VIB]     = mean_sq > r_vib_limit;
        new_flags[lsam_pkg::FLAG_SUPPLY]  = (r0_sup < r_sup_low) || (r0_sup > r_sup_high);
    end

    always_comb begin
        n_flags    = r_flags;
        n_latch    = r_latch;
        n_relay    = r_relay;
        n_buzzer   = r_buzzer;
        n_user_off = r_user_off;
        n_led      = r_led;
        n_sum      = r_sum;
        n_widx     = r_widx;
        n_full     = r_full;
        ram_we     = 1'b0;
        if (commit) begin
            case (lsam_pkg::t_req'(r0_type))
                lsam_pkg::REQ_SAMPLE: begin
                    ram_we = 1'b1;
                    n_sum  = r_sum - SUM_W'(old_sq) + SUM_W'(n_sq);
                    if (r_widx == IDX_LAST) begin
                        n_widx = '0;
                        n_full = 1'b1;
                    end else begin
                        n_widx = r_widx + IDX_W'(1);
                    end
                end
                lsam_pkg::REQ_REPORT: begin
                    if (!r_latch) begin
                        n_flags = r_flags | new_flags;
                    end
                    if (|n_flags) begin
                        n_latch  = 1'b1;
                        n_relay  = 1'b0;
                        n_buzzer = 1'b1;
                    end
                    n_led = (|n_flags) && !r_user_off;
                end
                lsam_pkg::REQ_LED_OFF: begin
                    n_user_off = 1'b1;
                    n_led      = 1'b0;
                end
                lsam_pkg::REQ_RELAY_ON: begin
                    n_relay = 1'b1;
                    n_latch = 1'b0;
                end
                lsam_pkg::REQ_RELAY_OFF: begin
                    n_relay = 1'b0;
                end
                lsam_pkg::REQ_ALARM_CLR: begin
                    n_latch    = 1'b0;
                    n_flags    = '0;
                    n_user_off = 1'b0;
                    n_buzzer   = 1'b0;
                    n_relay    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags    <= '0;
            r_latch    <= 1'b0;
            r_relay    <= 1'b1;
            r_buzzer   <= 1'b0;
            r_user_off <= 1'b0;
            r_led      <= 1'b0;
            r_sum      <= '0;
            r_widx     <= '0;
            r_full     <= 1'b0;
        end else begin
            r_flags    <= n_flags;
            r_latch    <= n_latch;
            r_relay    <= n_relay;
            r_buzzer   <= n_buzzer;
            r_user_off <= n_user_off;
            r_led      <= n_led;
            r_sum      <= n_sum;
            r_widx     <= n_widx;
            r_full     <= n_full;
        end
    end

    // read ahead at the next write slot so the old entry is ready on commit
    lsam_ram #(
        .WIDTH (SQ_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata (n_sq),
        .i_raddr (n_widx),
        .o_rdata (ram_rdata)
    );

    // result
    assign o_res.valid           = r_vld[NSTAGE-1];
    assign o_res.alarm_temp      = r_flags[lsam_pkg::FLAG_TEMP];
    assign o_res.alarm_current   = r_flags[lsam_pkg::FLAG_CURRENT];
    assign o_res.alarm_power     = r_flags[lsam_pkg::FLAG_POWER];
    assign o_res.alarm_vibration = r_flags[lsam_pkg::FLAG_VIB];
    assign o_res.alarm_supply    = r_flags[lsam_pkg::FLAG_SUPPLY];
    assign o_res.alarm_any       = |r_flags;
    assign o_res.relay_closed    = r_relay;
    assign o_res.buzzer_on       = r_buzzer;
    assign o_res.led_on          = r_led;
    assign o_res.latched         = r_latch;
    assign o_res.mean_square     = mean_sq;

endmodule
`default_nettype wire

// ===== src/lsam_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module lsam_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic                         i_alarm_temp,
    input logic                         i_alarm_current,
    input logic                         i_alarm_power,
    input logic                         i_alarm_vibration,
    input logic                         i_alarm_supply,
    input logic                         i_alarm_any,
    input logic                         i_relay_closed,
    input logic                         i_buzzer_on,
    input logic                         i_latched,
    input logic [lsam_pkg::QUO_W-1:0]   i_mean_square
);

    `LSAM_ASSERT(a_any_is_or, i_clk, i_rst_n, i_res_valid |-> (i_alarm_any == (i_alarm_temp | i_alarm_current | i_alarm_power | i_alarm_vibration | i_alarm_supply)))
    `LSAM_ASSERT(a_latch_needs_flag, i_clk, i_rst_n, (i_res_valid && (i_latched || i_buzzer_on)) |-> i_alarm_any)
    `LSAM_ASSERT(a_latch_opens_relay, i_clk, i_rst_n, (i_res_valid && i_latched) |-> !i_relay_closed)
    `LSAM_ASSERT(a_stall_holds, i_clk, i_rst_n, (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_mean_square) && $stable(i_alarm_any) && $stable(i_latched)))

endmodule

bind latched_sensor_alarm_monitor_unit lsam_checker u_lsam_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_alarm_temp      (o_res.alarm_temp),
    .i_alarm_current   (o_res.alarm_current),
    .i_alarm_power     (o_res.alarm_power),
    .i_alarm_vibration (o_res.alarm_vibration),
    .i_alarm_supply    (o_res.alarm_supply),
    .i_alarm_any       (o_res.alarm_any),
    .i_relay_closed    (o_res.relay_closed),
    .i_buzzer_on       (o_res.buzzer_on),
    .i_latched         (o_res.latched),
    .i_mean_square     (o_res.mean_square)
);
`default_nettype wire

// ===== tb/latched_sensor_alarm_monitor_unit_tb.sv =====
`timescale 1ns / 1ps
module latched_sensor_alarm_monitor_unit_tb;
    import lsam_pkg::*;

    localparam int unsigned WINDOW_DEPTH = 256;
    localparam int unsigned RING_AW      = 8;
    localparam int          MAX_IDLE     = 2000;
    localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

    typedef struct {
        logic [REQ_W-1:0]         code;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
        logic [ADC_W-1:0]         cur;
        logic [ADC_W-1:0]         sup;
        logic signed [ADC_W-1:0]  temp;
    } request_t;

    typedef struct {
        logic             alarm_temp;
        logic             alarm_current;
        logic             alarm_power;
        logic             alarm_vibration;
        logic             alarm_supply;
        logic             alarm_any;
        logic             relay_closed;
        logic             buzzer_on;
        logic             led_on;
        logic             latched;
        logic [QUO_W-1:0] mean_square;
    } status_t;

    class alarm_state_tracker;
        logic [SQ_W-1:0]         ring [WINDOW_DEPTH];
        logic [SUM_W-1:0]        window_sum;
        logic [RING_AW-1:0]      widx;
        logic [NFLAG-1:0]        flags;
        logic                    latch, relay, buzzer, led_off, led;
        logic [ADC_W-1:0]        cur_offset, cur_limit, pwr_limit, sup_low, sup_high;
        logic signed [ADC_W-1:0] temp_limit;
        logic [LIMIT_W-1:0]      vib_limit;
        status_t                 pending_status [$];
        int                      mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            window_sum = '0;
            widx       = '0;
            flags      = '0;
            latch      = 1'b0;
            relay      = 1'b1;
            buzzer     = 1'b0;
            led_off    = 1'b0;
            led        = 1'b0;
            cur_offset = CUR_OFFSET_RST;
            cur_limit  = CUR_LIMIT_RST;
            pwr_limit  = PWR_LIMIT_RST;
            temp_limit = TEMP_LIMIT_RST;
            sup_low    = SUP_LOW_RST;
            sup_high   = SUP_HIGH_RST;
            vib_limit  = VIB_LIMIT_RST;
            mismatches = 0;
        endfunction

        function logic [QUO_W-1:0] mean_square();
            return QUO_W'(window_sum / WINDOW_DEPTH);
        endfunction

        function void take_config(t_cfg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CUR_OFFSET: cur_offset = data[ADC_W-1:0];
                CFG_CUR_LIMIT:  cur_limit  = data[ADC_W-1:0];
                CFG_PWR_LIMIT:  pwr_limit  = data[ADC_W-1:0];
                CFG_TEMP_LIMIT: temp_limit = data[ADC_W-1:0];
                CFG_SUP_LOW:    sup_low    = data[ADC_W-1:0];
                CFG_SUP_HIGH:   sup_high   = data[ADC_W-1:0];
                CFG_VIB_LIMIT:  vib_limit  = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_request(request_t r);
            longint          x, y, z;
            logic [SQ_W-1:0] sq;
            int              diff;
            status_t         s;
            case (r.code)
                REQ_SAMPLE: begin
                    x = longint'(r.ax);
                    y = longint'(r.ay);
                    z = longint'(r.az);
                    sq = SQ_W'(x * x + y * y + z * z);
                    window_sum = window_sum - SUM_W'(ring[widx]) + SUM_W'(sq);
                    ring[widx] = sq;
                    widx++;
                end
                REQ_REPORT: begin
                    if (!latch) begin
                        diff = int'(r.cur) - int'(cur_offset);
                        if (diff >= -int'(CUR_DEADBAND) && diff <= int'(CUR_DEADBAND))
                            diff = 0;
                        if (r.temp != TEMP_INV_HIGH && r.temp != TEMP_INV_LOW &&
                            r.temp > temp_limit)
                            flags[FLAG_TEMP] = 1'b1;
                        if (diff > int'(cur_limit)) flags[FLAG_CURRENT] = 1'b1;
                        if (diff > int'(pwr_limit)) flags[FLAG_POWER] = 1'b1;
                        if (mean_square() > vib_limit) flags[FLAG_VIB] = 1'b1;
                        if (r.sup < sup_low || r.sup > sup_high) flags[FLAG_SUPPLY] = 1'b1;
                    end
                    if (flags != '0) begin
                        latch  = 1'b1;
                        relay  = 1'b0;
                        buzzer = 1'b1;
                    end
                    led = (flags != '0) && !led_off;
                end
                REQ_LED_OFF: begin
                    led_off = 1'b1;
                    led     = 1'b0;
                end
                REQ_RELAY_ON: begin
                    relay = 1'b1;
                    latch = 1'b0;
                end
                REQ_RELAY_OFF: relay = 1'b0;
                REQ_ALARM_CLR: begin
                    latch   = 1'b0;
                    flags   = '0;
                    led_off = 1'b0;
                    buzzer  = 1'b0;
                    relay   = 1'b1;
                end
                default: ;
            endcase
            s.alarm_temp      = flags[FLAG_TEMP];
            s.alarm_current   = flags[FLAG_CURRENT];
            s.alarm_power     = flags[FLAG_POWER];
            s.alarm_vibration = flags[FLAG_VIB];
            s.alarm_supply    = flags[FLAG_SUPPLY];
            s.alarm_any       = (flags != '0);
            s.relay_closed    = relay;
            s.buzzer_on       = buzzer;
            s.led_on          = led;
            s.latched         = latch;
            s.mean_square     = mean_square();
            pending_status.push_back(s);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (pending_status.size() == 0) begin
                $error("result transfer with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_status.pop_front();
            compare_field("alarm_temp", 32'(want.alarm_temp), 32'(got.alarm_temp));
            compare_field("alarm_current", 32'(want.alarm_current), 32'(got.alarm_current));
            compare_field("alarm_power", 32'(want.alarm_power), 32'(got.alarm_power));
            compare_field("alarm_vibration", 32'(want.alarm_vibration),
                          32'(got.alarm_vibration));
            compare_field("alarm_supply", 32'(want.alarm_supply), 32'(got.alarm_supply));
            compare_field("alarm_any", 32'(want.alarm_any), 32'(got.alarm_any));
            compare_field("relay_closed", 32'(want.relay_closed), 32'(got.relay_closed));
            compare_field("buzzer_on", 32'(want.buzzer_on), 32'(got.buzzer_on));
            compare_field("led_on", 32'(want.led_on), 32'(got.led_on));
            compare_field("latched", 32'(want.latched), 32'(got.latched));
            compare_field("mean_square", want.mean_square, got.mean_square);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lsam_req_if req_ch ();
    lsam_res_if res_ch ();
    lsam_cfg_if cfg_ch ();

    latched_sensor_alarm_monitor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    alarm_state_tracker tracker = new();
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int hold_rx = 0;
    int idle_cycles = 0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= MAX_IDLE) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receive side: random stalls, one long hold-off on request
    initial begin
        int      n;
        status_t got;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            n = rx_idle ? $urandom_range(0, 14) : 0;
            if (hold_rx > 0) begin
                n = hold_rx;
                hold_rx = 0;
            end
            if (n > 0) begin
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            got.alarm_temp      = res_ch.alarm_temp;
            got.alarm_current   = res_ch.alarm_current;
            got.alarm_power     = res_ch.alarm_power;
            got.alarm_vibration = res_ch.alarm_vibration;
            got.alarm_supply    = res_ch.alarm_supply;
            got.alarm_any       = res_ch.alarm_any;
            got.relay_closed    = res_ch.relay_closed;
            got.buzzer_on       = res_ch.buzzer_on;
            got.led_on          = res_ch.led_on;
            got.latched         = res_ch.latched;
            got.mean_square     = res_ch.mean_square;
            tracker.check_status(got);
        end
    end

    function automatic request_t make_request(logic [REQ_W-1:0] code, int ax, int ay, int az,
                                              int cur, int sup, int temp);
        request_t r;
        r.code = code;
        r.ax   = AXIS_W'(ax);
        r.ay   = AXIS_W'(ay);
        r.az   = AXIS_W'(az);
        r.cur  = ADC_W'(cur);
        r.sup  = ADC_W'(sup);
        r.temp = ADC_W'(temp);
        return r;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic signed [AXIS_W-1:0] random_axis();
        int pick;
        int amp;
        pick = $urandom_range(0, 9);
        if (pick >= 8) return AXIS_W'($urandom);
        amp = (pick < 5) ? 2047 : 8191;
        return AXIS_W'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       sel;
        int       v;
        r.code = REQ_SAMPLE;
        r.ax   = AXIS_W'($urandom);
        r.ay   = AXIS_W'($urandom);
        r.az   = AXIS_W'($urandom);
        r.cur  = ADC_W'($urandom);
        r.sup  = ADC_W'($urandom);
        r.temp = ADC_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            r.ax = random_axis();
            r.ay = random_axis();
            r.az = random_axis();
        end else if (sel < 75) begin
            r.code = REQ_REPORT;
            if ($urandom_range(0, 1)) begin
                v = int'(tracker.cur_offset) + int'($urandom_range(0, tracker.pwr_limit + 16)) - 8;
                r.cur = ADC_W'(clamp(v, 0, 4095));
            end
            sel = $urandom_range(0, 9);
            if (sel < 4)
                r.sup = ADC_W'(clamp(int'(tracker.sup_low) + int'($urandom_range(0, 6)) - 3,
                                     0, 4095));
            else if (sel < 7)
                r.sup = ADC_W'(clamp(int'(tracker.sup_high) + int'($urandom_range(0, 6)) - 3,
                                     0, 4095));
            sel = $urandom_range(0, 9);
            if (sel == 0)
                r.temp = $urandom_range(0, 1) ? TEMP_INV_HIGH : TEMP_INV_LOW;
            else if (sel < 5)
                r.temp = ADC_W'(clamp(int'(tracker.temp_limit) + int'($urandom_range(0, 6)) - 3,
                                      -2048, 2047));
        end else if (sel < 80) begin
            r.code = REQ_LED_OFF;
        end else if (sel < 85) begin
            r.code = REQ_RELAY_ON;
        end else if (sel < 89) begin
            r.code = REQ_RELAY_OFF;
        end else if (sel < 98) begin
            r.code = REQ_ALARM_CLR;
        end else begin
            r.code = (sel == 98) ? REQ_UNUSED_A : REQ_UNUSED_B;
        end
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] setting_value(int mode, t_cfg idx);
        case (mode)
            0: return (idx == CFG_TEMP_LIMIT) ? 32'h0000_0800 : 32'd0;
            1: begin
                if (idx == CFG_VIB_LIMIT) return 32'hFFFF_FFFF;
                return (idx == CFG_TEMP_LIMIT) ? 32'h0000_07FF : 32'h0000_0FFF;
            end
            2: begin
                case (idx)
                    CFG_CUR_OFFSET: return $urandom_range(3000, 3200);
                    CFG_CUR_LIMIT:  return $urandom_range(0, 200);
                    CFG_PWR_LIMIT:  return $urandom_range(100, 800);
                    CFG_TEMP_LIMIT: return 32'(12'(int'($urandom_range(0, 900)) - 100));
                    CFG_SUP_LOW:    return $urandom_range(300, 900);
                    CFG_SUP_HIGH:   return $urandom_range(2500, 3500);
                    default:        return $urandom_range(1000000, 200000000);
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(request_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.code;
        req_ch.accel_x     <= r.ax;
        req_ch.accel_y     <= r.ay;
        req_ch.accel_z     <= r.az;
        req_ch.current_adc <= r.cur;
        req_ch.supply_adc  <= r.sup;
        req_ch.temperature <= r.temp;
        do @(posedge i_clk); while (!req_ch.ready);
        tracker.take_request(r);
    endtask

    task automatic wait_drained();
        while (tracker.pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_settings(int mode);
        t_cfg                  idx;
        logic [CFG_DATA_W-1:0] data;
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (12) @(posedge i_clk);
        for (int i = 0; i <= int'(CFG_VIB_LIMIT); i++) begin
            idx  = t_cfg'(i);
            data = setting_value(mode, idx);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= data;
            do @(posedge i_clk); while (!cfg_ch.ready);
            tracker.take_config(idx, data);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        request_t directed [$];
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_SAMPLE;
        req_ch.accel_x     <= '0;
        req_ch.accel_y     <= '0;
        req_ch.accel_z     <= '0;
        req_ch.current_adc <= '0;
        req_ch.supply_adc  <= '0;
        req_ch.temperature <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_CUR_OFFSET;
        cfg_ch.data        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(make_request(REQ_SAMPLE, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_SAMPLE, -32768, -32768, -32768, 4095, 4095, -1));
        directed.push_back(make_request(REQ_SAMPLE, 32767, 32767, 32767, 0, 0, 0));
        directed.push_back(make_request(REQ_SAMPLE, -32768, 32767, 21845, 2730, 1365, 1365));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 3102, 1000, 0));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 3102, 1000, 1360));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 3102, 1000, -2032));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 3102, 1000, 497));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 4095, 0, 2047));
        directed.push_back(make_request(REQ_LED_OFF, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 3102, 1000, 0));
        directed.push_back(make_request(REQ_RELAY_OFF, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_RELAY_ON, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 3227, 1000, 0));
        directed.push_back(make_request(REQ_ALARM_CLR, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 3108, 564, 496));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 0, 4095, -2048));
        directed.push_back(make_request(REQ_UNUSED_A, 1, 2, 3, 4, 5, 6));
        directed.push_back(make_request(REQ_UNUSED_B, -1, -2, -3, 7, 8, 9));
        directed.push_back(make_request(REQ_ALARM_CLR, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 3096, 563, 0));
        directed.push_back(make_request(REQ_ALARM_CLR, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_REPORT, 0, 0, 0, 4095, 2933, -2048));
        directed.push_back(make_request(REQ_ALARM_CLR, 0, 0, 0, 0, 0, 0));
        foreach (directed[i]) send_request(directed[i]);

        for (int phase = 0; phase < 10; phase++) begin
            write_settings(phase % 4);
            tx_idle = (phase % 3 != 1) && (phase != 5);
            rx_idle = (phase % 4 != 2);
            if (phase == 5) hold_rx = 80;
            for (int k = 0; k < 108; k++) begin
                if (phase == 3 && k == 54) begin
                    req_ch.valid <= 1'b0;
                    wait_drained();
                end
                send_request(random_request());
            end
        end
        req_ch.valid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_status.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
